// File: src/sfr_pkg.sv
// Shared types and constants for the streaming find-and-replace block.
package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int DATA_W = 64;
   localparam int LEN_W  = 4;
   localparam int QDEPTH = 2;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES = 2'd0,
      REG_PATTERN_LEN   = 2'd1,
      REG_REPLACE_BYTES = 2'd2,
      REG_REPLACE_LEN   = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [DATA_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]  pattern_len;
      logic [DATA_W-1:0] replace_bytes;
      logic [LEN_W-1:0]  replace_len;
      logic              len_wr;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  count;
      logic              eot;
   } cmd_type;

endpackage

// File: src/sfr_csr.sv
// Configuration registers with an APB-style access port and length clamping.
module sfr_csr
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   localparam int PLIM = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
   localparam int RLIM = (MAX_REPLACE < 8) ? MAX_REPLACE : 8;

   logic [DATA_W-1:0] pattern_bytes_ff;
   logic [LEN_W-1:0]  pattern_len_ff;
   logic [DATA_W-1:0] replace_bytes_ff;
   logic [LEN_W-1:0]  replace_len_ff;
   logic              wr;
   reg_idx_type       idx;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[4:3]);
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff <= '0;
         pattern_len_ff   <= LEN_W'(1);
         replace_bytes_ff <= '0;
         replace_len_ff   <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_PATTERN_BYTES: pattern_bytes_ff <= pwdata;
            REG_PATTERN_LEN:   pattern_len_ff   <= pwdata[LEN_W-1:0];
            REG_REPLACE_BYTES: replace_bytes_ff <= pwdata;
            REG_REPLACE_LEN:   replace_len_ff   <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PATTERN_BYTES: prdata = pattern_bytes_ff;
         REG_PATTERN_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_len_ff};
         REG_REPLACE_BYTES: prdata = replace_bytes_ff;
         REG_REPLACE_LEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, replace_len_ff};
         default:           prdata = '0;
      endcase
   end

   always_comb begin
      cfg.pattern_bytes = pattern_bytes_ff;
      cfg.replace_bytes = replace_bytes_ff;
      cfg.len_wr        = wr && (idx == REG_PATTERN_LEN);
      priority if (pattern_len_ff == '0) begin
         cfg.pattern_len = LEN_W'(1);
      end else if (pattern_len_ff > LEN_W'(PLIM)) begin
         cfg.pattern_len = LEN_W'(PLIM);
      end else begin
         cfg.pattern_len = pattern_len_ff;
      end
      if (replace_len_ff > LEN_W'(RLIM)) begin
         cfg.replace_len = LEN_W'(RLIM);
      end else begin
         cfg.replace_len = replace_len_ff;
      end
   end

endmodule

// File: src/sfr_front.sv
// Front end: holds the lookahead window, compares against the pattern, issues commands.
module sfr_front
   import sfr_pkg::*;
#(
   parameter int WIN = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_eot,
   input  logic              q_full,
   output logic              push,
   output cmd_type           cmd
);

   localparam int FW = $clog2(WIN + 1);

   logic [BYTE_W-1:0] win_ff [WIN];
   logic [BYTE_W-1:0] win_in [WIN];
   logic [BYTE_W-1:0] wcur   [WIN];
   logic [FW-1:0]     fill_ff;
   logic [FW-1:0]     fill_in;
   logic [LEN_W-1:0]  fill_inc;
   logic [DATA_W-1:0] flush_data;
   logic              full;
   logic              match;
   logic              accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         wcur[i] = (fill_ff == FW'(i)) ? in_byte : win_ff[i];
      end
      fill_inc = LEN_W'(fill_ff) + LEN_W'(1);
      full     = (fill_inc == cfg.pattern_len);
      match    = 1'b1;
      for (int i = 0; i < WIN; i++) begin
         if ((LEN_W'(i) < cfg.pattern_len) &&
             (wcur[i] != cfg.pattern_bytes[BYTE_W*i +: BYTE_W])) begin
            match = 1'b0;
         end
      end
      flush_data = '0;
      for (int i = 0; i < WIN; i++) begin
         flush_data[BYTE_W*i +: BYTE_W] = wcur[i];
      end
   end

   always_comb begin
      win_in  = wcur;
      cmd.eot = in_eot;
      priority if (full && match) begin
         cmd.data  = cfg.replace_bytes;
         cmd.count = cfg.replace_len;
         fill_in   = '0;
      end else if (full) begin
         cmd.data  = flush_data;
         cmd.count = in_eot ? cfg.pattern_len : LEN_W'(1);
         fill_in   = in_eot ? '0 : fill_ff;
         for (int i = 0; i < WIN - 1; i++) begin
            win_in[i] = wcur[i+1];
         end
      end else begin
         cmd.data  = flush_data;
         cmd.count = in_eot ? fill_inc : '0;
         fill_in   = in_eot ? '0 : FW'(fill_inc);
      end
      push = accept && ((cmd.count != '0) || in_eot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cfg.len_wr) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// File: src/sfr_queue.sv
// Short command queue between the front end and the back end.
module sfr_queue
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   cmd_type       entry_ff [QDEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full       = (count_ff == CW'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/sfr_back.sv
// Back end: expands each command into result transfers through an output register.
module sfr_back
   import sfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_byte_valid,
   output logic              out_run_last,
   output logic              out_text_done
);

   logic [2:0]        idx_ff;
   logic [2:0]        idx_in;
   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              byte_valid_ff;
   logic              run_last_ff;
   logic              text_done_ff;
   logic              advance;
   logic              last;
   logic              empty_cmd;

   assign empty_cmd = (head_cmd.count == '0);
   assign last      = empty_cmd || ((LEN_W'(idx_ff) + LEN_W'(1)) == head_cmd.count);
   assign advance   = head_valid && (!valid_ff || out_ready);
   assign pop       = advance && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = last ? '0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff       <= empty_cmd ? '0 : head_cmd.data[{idx_ff, 3'b000} +: BYTE_W];
         byte_valid_ff <= !empty_cmd;
         run_last_ff   <= last;
         text_done_ff  <= last && head_cmd.eot;
      end
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign out_byte_valid = byte_valid_ff;
   assign out_run_last   = run_last_ff;
   assign out_text_done  = text_done_ff;

endmodule

// File: src/stream_find_replace.sv
// Streaming find-and-replace: top level tying registers, front end, queue and back end.
// The block rewrites a byte stream, replacing each non-overlapping occurrence of a
// pattern of 1 to 8 bytes with a replacement of 0 to 8 bytes and passing all other
// bytes through; bytes still held as lookahead at the end of the string are sent
// unchanged. Ordinary text, in which a byte yields at most one result, streams at one
// byte per clock while the output is ready. A byte that completes a match, or ends the
// string, yields up to eight results, and the output register sends one result per
// cycle while the output is ready; a two-entry command queue lets input continue while
// that expansion drains, and the input stalls only once the queue is full.
module stream_find_replace
   import sfr_pkg::*;
#(
   parameter int MAX_PATTERN = 8,
   parameter int MAX_REPLACE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,   // run_last
   output logic [1:0]  rsp_tuser,   // text_done, byte_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int WIN = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    q_full;
   logic    head_valid;
   logic    byte_valid;
   logic    text_done;

   sfr_csr #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_REPLACE (MAX_REPLACE)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sfr_front #(
      .WIN (WIN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_eot   (req_tlast),
      .q_full   (q_full),
      .push     (push),
      .cmd      (push_cmd)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (rsp_tdata),
      .out_byte_valid (byte_valid),
      .out_run_last   (rsp_tlast),
      .out_text_done  (text_done)
   );

   assign rsp_tuser = {text_done, byte_valid};

endmodule
